@@ rtl/count_min_sketch_update_macros.svh @@
`ifndef COUNT_MIN_SKETCH_UPDATE_MACROS_SVH
`define COUNT_MIN_SKETCH_UPDATE_MACROS_SVH

// antecedent implies consequent in the same cycle
`define CMSU_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("cmsu assertion failed");

// antecedent implies consequent in the next cycle
`define CMSU_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("cmsu assertion failed");

`endif

@@ rtl/cmsu_pkg.sv @@
package cmsu_pkg;

    localparam int OP_W     = 2;
    localparam int KEY_W    = 32;
    localparam int ROW_W    = 2;
    localparam int COLUMN_W = 10;
    localparam int SBIT_W   = 5;
    localparam int SVAL_W   = 32;
    localparam int OUT_W    = 32;
    localparam int CFG_W    = 11;
    localparam int COLS_W   = 11;
    localparam int ROWS_W   = 3;
    localparam int CIDX_W   = 1;

    localparam logic [OP_W-1:0] OP_UPDATE = 2'd0;
    localparam logic [OP_W-1:0] OP_SEED   = 2'd1;
    localparam logic [OP_W-1:0] OP_READ   = 2'd2;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

    localparam logic [CIDX_W-1:0] CFG_COLUMNS = 1'd0;
    localparam logic [CIDX_W-1:0] CFG_ROWS    = 1'd1;

    localparam logic [COLS_W-1:0] COLS_RESET = 11'd1024;
    localparam logic [ROWS_W-1:0] ROWS_RESET = 3'd4;

    typedef struct packed {
        logic [OP_W-1:0]     operation;
        logic [KEY_W-1:0]    key;
        logic [ROW_W-1:0]    row;
        logic [COLUMN_W-1:0] column;
        logic [SBIT_W-1:0]   seed_bit;
        logic [SVAL_W-1:0]   seed_value;
    } t_cmd;

    typedef struct packed {
        logic [OUT_W-1:0] counter_value;
        logic [OUT_W-1:0] observed_tuples;
    } t_result;

    // per-cycle controls broadcast to every cell
    typedef struct packed {
        logic seed_we;
        logic hash_ld;
        logic mod_step;
        logic rd;
        logic rd_addr;
        logic wr_inc;
        logic clr;
        logic chain;
    } t_cell_ctrl;

endpackage

@@ rtl/count_min_sketch_update.sv @@
// Count-min sketch with H3 hashing: one cell per sketch row, each holding its seed words and
// counter memory. A transaction is taken when start is high and busy low; its single result
// appears on o_result for one cycle with o_valid, and cannot be stalled. Steps: update loads
// the hash, takes one remainder bit per cycle in each row cell, then reads and increments the
// counter; seed load writes one seed word; counter read reads and passes the value down the
// row chain; clear zeroes one counter address per cycle in all rows. After reset the counters
// are swept to zero with busy high; configuration writes are taken always.
module count_min_sketch_update #(
    parameter int KEY_BITS     = 32,
    parameter int HASH_BITS    = 32,
    parameter int MAX_COLUMNS  = 1024,
    parameter int MAX_ROWS     = 4,
    parameter int COUNTER_BITS = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  cmsu_pkg::t_cmd                     i_cmd,
    output logic                               o_valid,
    output cmsu_pkg::t_result                  o_result,
    input  logic                               i_cfg_we,
    input  logic [cmsu_pkg::CIDX_W-1:0]        i_cfg_idx,
    input  logic [cmsu_pkg::CFG_W-1:0]         i_cfg_data
);
    import cmsu_pkg::*;

    `include "count_min_sketch_update_macros.svh"

    localparam int CW    = $clog2(MAX_COLUMNS + 1);
    localparam int COL_W = $clog2(MAX_COLUMNS);
    localparam int KB_W  = $clog2(KEY_BITS);
    localparam int CNT_W = $clog2(MAX_COLUMNS + HASH_BITS + MAX_ROWS);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CLEAR = 4'd1;
    localparam logic [3:0] S_SEED  = 4'd2;
    localparam logic [3:0] S_HASH  = 4'd3;
    localparam logic [3:0] S_MOD   = 4'd4;
    localparam logic [3:0] S_RD    = 4'd5;
    localparam logic [3:0] S_WR    = 4'd6;
    localparam logic [3:0] S_CHAIN = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;

    logic [3:0]             r_state, n_state;
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    logic                   r_silent;
    logic [COLS_W-1:0]      r_cols_cfg;
    logic [ROWS_W-1:0]      r_rows_cfg;
    logic [OUT_W-1:0]       r_tuples;
    logic                   r_is_read;
    logic [MAX_ROWS-1:0]    r_sel;
    logic [CW-1:0]          r_cols;
    logic [KEY_BITS-1:0]    r_key;
    logic [COL_W-1:0]       r_column;
    logic [KB_W-1:0]        r_seed_idx;
    logic [HASH_BITS-1:0]   r_seed_val;
    logic                   r_valid;
    t_result                r_result;

    logic                   w_accept;
    logic [CW-1:0]          w_cols;
    int                     w_rows;
    logic [MAX_ROWS-1:0]    w_sel;
    logic [COL_W-1:0]       w_addr;
    t_cell_ctrl             w_ctrl;
    logic [COUNTER_BITS-1:0] w_chain [MAX_ROWS+1];

    assign w_accept = start && !busy;
    assign busy     = (r_state != S_IDLE);

    always_comb begin
        if (r_cols_cfg == '0) begin
            w_cols = CW'(1);
        end else if (int'(r_cols_cfg) > MAX_COLUMNS) begin
            w_cols = CW'(MAX_COLUMNS);
        end else begin
            w_cols = CW'(r_cols_cfg);
        end
        if (r_rows_cfg == '0) begin
            w_rows = 1;
        end else if (int'(r_rows_cfg) > MAX_ROWS) begin
            w_rows = MAX_ROWS;
        end else begin
            w_rows = int'(r_rows_cfg);
        end
    end

    always_comb begin
        for (int r = 0; r < MAX_ROWS; r++) begin
            unique case (i_cmd.operation)
                OP_UPDATE: w_sel[r] = (r < w_rows);
                OP_SEED:   w_sel[r] = (int'(i_cmd.row) == r) && (int'(i_cmd.seed_bit) < KEY_BITS);
                OP_READ:   w_sel[r] = (int'(i_cmd.row) == r)
                                      && (int'(i_cmd.column) < MAX_COLUMNS);
                default:   w_sel[r] = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols_cfg <= COLS_RESET;
            r_rows_cfg <= ROWS_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_COLUMNS: r_cols_cfg <= i_cfg_data;
                CFG_ROWS:    r_rows_cfg <= i_cfg_data[ROWS_W-1:0];
                default:     ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_sel      <= w_sel;
            r_cols     <= w_cols;
            r_key      <= KEY_BITS'(i_cmd.key);
            r_column   <= COL_W'(i_cmd.column);
            r_seed_idx <= KB_W'(i_cmd.seed_bit);
            r_seed_val <= HASH_BITS'(i_cmd.seed_value);
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        w_ctrl  = '0;
        unique case (r_state)
            S_IDLE: begin
                n_cnt = '0;
                if (w_accept) begin
                    unique case (i_cmd.operation)
                        OP_UPDATE: n_state = S_HASH;
                        OP_SEED:   n_state = S_SEED;
                        OP_READ:   n_state = S_RD;
                        default:   n_state = S_CLEAR;
                    endcase
                end
            end
            S_CLEAR: begin
                w_ctrl.clr = 1'b1;
                n_cnt      = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(MAX_COLUMNS - 1)) begin
                    n_cnt   = '0;
                    n_state = r_silent ? S_IDLE : S_OUT;
                end
            end
            S_SEED: begin
                w_ctrl.seed_we = 1'b1;
                n_state        = S_OUT;
            end
            S_HASH: begin
                w_ctrl.hash_ld = 1'b1;
                n_state        = S_MOD;
            end
            S_MOD: begin
                w_ctrl.mod_step = 1'b1;
                n_cnt           = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(HASH_BITS - 1)) begin
                    n_cnt   = '0;
                    n_state = S_RD;
                end
            end
            S_RD: begin
                w_ctrl.rd      = 1'b1;
                w_ctrl.rd_addr = r_is_read;
                n_state        = r_is_read ? S_CHAIN : S_WR;
            end
            S_WR: begin
                w_ctrl.wr_inc = 1'b1;
                n_state       = S_OUT;
            end
            S_CHAIN: begin
                w_ctrl.chain = 1'b1;
                n_cnt        = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(MAX_ROWS - 1)) begin
                    n_cnt   = '0;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_cnt     <= '0;
            r_silent  <= 1'b1;
            r_tuples  <= '0;
            r_is_read <= 1'b0;
            r_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_valid <= (r_state == S_OUT);
            if (w_accept) begin
                r_silent  <= 1'b0;
                r_is_read <= (i_cmd.operation == OP_READ);
                if (i_cmd.operation == OP_UPDATE) begin
                    if (r_tuples != '1) begin
                        r_tuples <= r_tuples + OUT_W'(1);
                    end
                end else if (i_cmd.operation == OP_CLEAR) begin
                    r_tuples <= '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT) begin
            r_result.counter_value   <= r_is_read ? OUT_W'(w_chain[MAX_ROWS]) : '0;
            r_result.observed_tuples <= r_tuples;
        end
    end

    assign w_addr     = (r_state == S_CLEAR) ? r_cnt[COL_W-1:0] : r_column;
    assign w_chain[0] = '0;

    for (genvar g = 0; g < MAX_ROWS; g++) begin : g_cell
        cmsu_cell #(
            .KEY_BITS     (KEY_BITS),
            .HASH_BITS    (HASH_BITS),
            .MAX_COLUMNS  (MAX_COLUMNS),
            .COUNTER_BITS (COUNTER_BITS)
        ) u_cell (
            .i_clk      (i_clk),
            .i_ctrl     (w_ctrl),
            .i_sel      (r_sel[g]),
            .i_key      (r_key),
            .i_cols     (r_cols),
            .i_addr     (w_addr),
            .i_seed_idx (r_seed_idx),
            .i_seed_val (r_seed_val),
            .i_chain    (w_chain[g]),
            .o_chain    (w_chain[g+1])
        );
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

    `CMSU_ASSERT_NEXT(a_accept_busy, w_accept, busy)
    `CMSU_ASSERT_NOW(a_valid_after_out, o_valid, $past(r_state) == S_OUT)
    `CMSU_ASSERT_NEXT(a_single_strobe, o_valid, !o_valid)
    `CMSU_ASSERT_NOW(a_read_zero, o_valid && !r_is_read, o_result.counter_value == '0)

endmodule

@@ rtl/cmsu_cell.sv @@
module cmsu_cell #(
    parameter int KEY_BITS     = 32,
    parameter int HASH_BITS    = 32,
    parameter int MAX_COLUMNS  = 1024,
    parameter int COUNTER_BITS = 32
) (
    input  logic                                 i_clk,
    input  cmsu_pkg::t_cell_ctrl                 i_ctrl,
    input  logic                                 i_sel,
    input  logic [KEY_BITS-1:0]                  i_key,
    input  logic [$clog2(MAX_COLUMNS+1)-1:0]     i_cols,
    input  logic [$clog2(MAX_COLUMNS)-1:0]       i_addr,
    input  logic [$clog2(KEY_BITS)-1:0]          i_seed_idx,
    input  logic [HASH_BITS-1:0]                 i_seed_val,
    input  logic [COUNTER_BITS-1:0]              i_chain,
    output logic [COUNTER_BITS-1:0]              o_chain
);
    import cmsu_pkg::*;

    localparam int CW    = $clog2(MAX_COLUMNS + 1);
    localparam int COL_W = $clog2(MAX_COLUMNS);

    logic [HASH_BITS-1:0]    r_seed [KEY_BITS];
    logic [COUNTER_BITS-1:0] r_mem  [MAX_COLUMNS];
    logic [HASH_BITS-1:0]    r_hash;
    logic [CW-1:0]           r_rem;
    logic [COUNTER_BITS-1:0] r_rdata;
    logic [COUNTER_BITS-1:0] r_acc;

    logic [HASH_BITS-1:0]    n_hash;
    logic [CW:0]             w_shift;
    logic [CW-1:0]           n_rem;
    logic [COL_W-1:0]        w_idx;
    logic [COL_W-1:0]        w_rd_idx;
    logic [COUNTER_BITS-1:0] w_inc;

    always_comb begin
        n_hash = '0;
        for (int i = 0; i < KEY_BITS; i++) begin
            if (i_key[i]) begin
                n_hash = n_hash ^ r_seed[i];
            end
        end
    end

    // one restoring remainder step per cycle, hash msb first
    always_comb begin
        w_shift = {r_rem, r_hash[HASH_BITS-1]};
        if (w_shift >= {1'b0, i_cols}) begin
            w_shift = w_shift - {1'b0, i_cols};
        end
        n_rem = w_shift[CW-1:0];
    end

    assign w_idx    = r_rem[COL_W-1:0];
    assign w_rd_idx = i_ctrl.rd_addr ? i_addr : w_idx;
    assign w_inc    = (r_rdata == '1) ? r_rdata : r_rdata + COUNTER_BITS'(1);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.seed_we && i_sel) begin
            r_seed[i_seed_idx] <= i_seed_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.hash_ld) begin
            r_hash <= n_hash;
            r_rem  <= '0;
        end else if (i_ctrl.mod_step) begin
            r_hash <= {r_hash[HASH_BITS-2:0], 1'b0};
            r_rem  <= n_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.clr) begin
            r_mem[i_addr] <= '0;
        end else if (i_ctrl.wr_inc && i_sel) begin
            r_mem[w_idx] <= w_inc;
        end
        if (i_ctrl.rd) begin
            r_rdata <= r_mem[w_rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.chain) begin
            r_acc <= i_chain | (i_sel ? r_rdata : '0);
        end
    end

    assign o_chain = r_acc;

endmodule

@@ tb/sv/tb_count_min_sketch_update.sv @@
`timescale 1ns / 1ps

module tb_count_min_sketch_update;
    import cmsu_pkg::*;

    localparam int N_ROWS = 4;
    localparam int N_COLS = 1024;
    localparam int N_KEYBITS = 32;

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    t_cmd i_cmd;
    logic o_valid;
    t_result o_result;
    logic i_cfg_we;
    logic [CIDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0] i_cfg_data;

    count_min_sketch_update dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .i_cmd(i_cmd),
        .o_valid(o_valid), .o_result(o_result), .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    // sketch shadow
    logic [31:0] seeds [N_ROWS*N_KEYBITS];
    logic [31:0] counters [N_ROWS*N_COLS];
    logic [31:0] tuples;
    logic [10:0] cols_reg;
    logic [2:0] rows_reg;

    t_cmd cmd_queue [$];
    t_result sketch_results [$];
    int errors;
    int idle_pct;
    bit drv_enable;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
        errors++;
    endtask

    function automatic t_result predict_sketch(input t_cmd c);
        t_result res;
        logic [31:0] h;
        int ncols, nrows, col;
        res = '0;
        ncols = (cols_reg == 0) ? 1 : (cols_reg > N_COLS ? N_COLS : cols_reg);
        nrows = (rows_reg == 0) ? 1 : (rows_reg > N_ROWS ? N_ROWS : rows_reg);
        case (c.operation)
            OP_UPDATE: begin
                for (int r = 0; r < nrows; r++) begin
                    h = '0;
                    for (int i = 0; i < N_KEYBITS; i++)
                        if (c.key[i]) h ^= seeds[r*N_KEYBITS+i];
                    col = h % ncols;
                    if (counters[r*N_COLS+col] != 32'hFFFF_FFFF)
                        counters[r*N_COLS+col]++;
                end
                if (tuples != 32'hFFFF_FFFF) tuples++;
            end
            OP_SEED: seeds[c.row*N_KEYBITS+c.seed_bit] = c.seed_value;
            OP_READ: res.counter_value = counters[c.row*N_COLS+c.column];
            default: begin
                foreach (counters[i]) counters[i] = '0;
                tuples = '0;
            end
        endcase
        res.observed_tuples = tuples;
        return res;
    endfunction

    function automatic t_cmd rand_cmd(input logic [1:0] op);
        t_cmd c;
        c.operation = op;
        c.key = $urandom;
        c.row = ROW_W'($urandom_range(0, 3));
        c.column = COLUMN_W'($urandom_range(0, 1023));
        c.seed_bit = SBIT_W'($urandom_range(0, 31));
        c.seed_value = $urandom;
        return c;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!(start && !busy) && start) begin
            start <= 1'b1;
        end else if (drv_enable && cmd_queue.size() > 0
                     && $urandom_range(0, 99) >= idle_pct) begin
            i_cmd <= cmd_queue.pop_front();
            start <= 1'b1;
        end else begin
            start <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy)
            sketch_results.push_back(predict_sketch(i_cmd));
    end

    // monitor
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid) begin
            if (sketch_results.size() == 0) begin
                report_mismatch("unexpected transaction", o_result.observed_tuples, '0);
            end else begin
                want = sketch_results.pop_front();
                if (o_result.counter_value !== want.counter_value)
                    report_mismatch("counter_value", o_result.counter_value,
                                    want.counter_value);
                if (o_result.observed_tuples !== want.observed_tuples)
                    report_mismatch("observed_tuples", o_result.observed_tuples,
                                    want.observed_tuples);
            end
        end
    end

    task automatic wait_drained();
        while (cmd_queue.size() > 0 || start || sketch_results.size() > 0)
            @(posedge i_clk);
        repeat (1100) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_COLUMNS) cols_reg = val;
        else rows_reg = val[2:0];
    endtask

    task automatic load_all_seeds();
        t_cmd c;
        for (int r = 0; r < N_ROWS; r++)
            for (int b = 0; b < N_KEYBITS; b++) begin
                c = rand_cmd(OP_SEED);
                c.row = ROW_W'(r);
                c.seed_bit = SBIT_W'(b);
                cmd_queue.push_back(c);
            end
    endtask

    task automatic random_phase(input int n, input int hot_keys);
        t_cmd c;
        logic [31:0] keys [8];
        foreach (keys[i]) keys[i] = $urandom;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 19))
                0: c = rand_cmd(OP_CLEAR);
                1, 2: c = rand_cmd(OP_SEED);
                3, 4, 5, 6: c = rand_cmd(OP_READ);
                default: begin
                    c = rand_cmd(OP_UPDATE);
                    if (hot_keys != 0 && $urandom_range(0, 1)) c.key = keys[$urandom_range(0, 7)];
                end
            endcase
            if (c.operation == OP_READ && $urandom_range(0, 1))
                c.column = COLUMN_W'($urandom_range(0, cols_reg > 16 ? 15 : cols_reg - 1));
            cmd_queue.push_back(c);
        end
    endtask

    initial begin
        t_cmd c;
        errors = 0;
        idle_pct = 37;
        drv_enable = 1'b0;
        start = 1'b0;
        i_cmd = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_COLUMNS;
        i_cfg_data = '0;
        cols_reg = COLS_RESET;
        rows_reg = ROWS_RESET;
        tuples = '0;
        foreach (counters[i]) counters[i] = '0;
        foreach (seeds[i]) seeds[i] = '0;
        i_rst_n = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: seeds first, then extremes
        load_all_seeds();
        c = rand_cmd(OP_UPDATE); c.key = '0; cmd_queue.push_back(c);
        c = rand_cmd(OP_UPDATE); c.key = '1; cmd_queue.push_back(c);
        c = rand_cmd(OP_UPDATE); c.key = 32'h1; cmd_queue.push_back(c);
        c = rand_cmd(OP_UPDATE); c.key = 32'h8000_0000; cmd_queue.push_back(c);
        c = rand_cmd(OP_READ); c.row = 0; c.column = 0; cmd_queue.push_back(c);
        c = rand_cmd(OP_READ); c.row = 3; c.column = 1023; cmd_queue.push_back(c);
        c = rand_cmd(OP_SEED); c.seed_value = '0; cmd_queue.push_back(c);
        c = rand_cmd(OP_SEED); c.seed_value = '1; cmd_queue.push_back(c);
        c = rand_cmd(OP_CLEAR); cmd_queue.push_back(c);
        c = rand_cmd(OP_READ); c.row = 0; c.column = 0; cmd_queue.push_back(c);
        drv_enable = 1'b1;
        wait_drained();

        // pause until idle, then extreme and out-of-range register values
        write_cfg(CFG_COLUMNS, CFG_W'(1));
        write_cfg(CFG_ROWS, CFG_W'(1));
        random_phase(200, 1);
        wait_drained();
        write_cfg(CFG_COLUMNS, CFG_W'(0));
        write_cfg(CFG_ROWS, CFG_W'(0));
        random_phase(150, 1);
        wait_drained();
        write_cfg(CFG_COLUMNS, CFG_W'(11'h7FF));
        write_cfg(CFG_ROWS, CFG_W'(7));
        random_phase(200, 0);
        wait_drained();
        write_cfg(CFG_COLUMNS, CFG_W'(1024));
        write_cfg(CFG_ROWS, CFG_W'(4));
        idle_pct = 0;
        random_phase(400, 1);
        wait_drained();
        idle_pct = 37;
        for (int p = 0; p < 5; p++) begin
            write_cfg(CFG_COLUMNS, CFG_W'($urandom_range(1, 1024)));
            write_cfg(CFG_ROWS, CFG_W'($urandom_range(1, 4)));
            random_phase(200, 1);
            wait_drained();
        end

        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        #100ms;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl
rtl/cmsu_pkg.sv
rtl/cmsu_cell.sv
rtl/count_min_sketch_update.sv
tb/sv/tb_count_min_sketch_update.sv
